// ===== design/isl_pkg.sv =====
// Package for the indexed sequence list: sizes, operation and status codes,
// the cell control bundle and value conversion helpers. No dependencies.
`default_nettype none
package isl_pkg;

	localparam int DEPTH       = 64;
	localparam int VALUE_WIDTH = 32;

	localparam int ACT_W   = 2;
	localparam int POS_W   = 6;
	localparam int VAL_W   = 32;
	localparam int OCNT_W  = 7;
	localparam int STAT_W  = 2;

	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam int IN_W    = ACT_W + POS_W + VAL_W;
	localparam int IN_TW   = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W   = VAL_W + OCNT_W + 1 + STAT_W;
	localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

	localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	typedef logic [VALUE_WIDTH-1:0] entry_t;

	typedef struct packed {
		logic             append_go;
		logic             remove_go;
		logic             read_go;
		logic [CMP_W-1:0] pos;
		logic [CMP_W-1:0] cnt;
	} cell_ctrl_t;

	function automatic entry_t to_store(input logic [VAL_W-1:0] v);
		logic signed [63:0] ext;
		ext = 64'(signed'(v));
		return ext[VALUE_WIDTH-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] from_store(input entry_t s);
		logic signed [63:0] ext;
		ext = 64'(signed'(s));
		return ext[VAL_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/isl_cell.sv =====
// One list cell: holds a single element, loads an appended value or its upper
// neighbor's element, and offers its element to the read bus. Uses isl_pkg.
`default_nettype none
module isl_cell import isl_pkg::*; (
	input  wire logic                 clk,
	input  wire logic [CMP_W-1:0]     idx,
	input  wire cell_ctrl_t           ctrl,
	input  wire entry_t               append_val,
	input  wire entry_t               next_val,
	output entry_t                    val,
	output entry_t                    rd_val
);

	entry_t data_q;

	always_ff @(posedge clk) begin
		if (ctrl.append_go && idx == ctrl.cnt) begin
			data_q <= append_val;
		end else if (ctrl.remove_go && idx >= ctrl.pos) begin
			data_q <= next_val;
		end
	end

	assign val    = data_q;
	assign rd_val = (ctrl.read_go && idx == ctrl.pos) ? data_q : '0;

endmodule
`default_nettype wire

// ===== design/indexed_sequence_list_top.sv =====
// Top level of the indexed sequence list: control, element count, the row of
// isl_cell instances and the result register. Uses isl_pkg and isl_cell.
//
// Ordered list of up to DEPTH signed values held in a row of cells. Each input
// word is one operation (append, remove at position, read at position; the
// fourth code changes nothing) and yields exactly one result word with the
// read value, the count after the operation, an empty flag and a status. On a
// remove all cells at and above the position take their neighbor's element at
// the same clock edge. The result of a word is registered when the word is
// taken, and a new word is taken in every cycle in which the result register
// is empty or being drained.
`default_nettype none
module indexed_sequence_list_top import isl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [IN_TW-1:0]  s_axis_tdata,  // action[1:0], position[7:2], value[39:8]
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [OUT_TW-1:0]      m_axis_tdata   // read_value[31:0], count[38:32],
	                                              // empty_res[39], status[41:40]
);

	logic [ACT_W-1:0]  action;
	logic [POS_W-1:0]  position;
	logic [VAL_W-1:0]  value;
	logic              go;
	logic              full;
	logic              in_range;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_next;
	logic [STAT_W-1:0] status;
	cell_ctrl_t        ctrl;
	entry_t            append_val;
	entry_t            cell_val [DEPTH];
	entry_t            cell_rd  [DEPTH];
	entry_t            rd_or;

	logic              out_valid_q;
	logic [VAL_W-1:0]  rd_q;
	logic [OCNT_W-1:0] ocnt_q;
	logic              empty_q;
	logic [STAT_W-1:0] status_q;

	assign action   = s_axis_tdata[ACT_W-1:0];
	assign position = s_axis_tdata[ACT_W+POS_W-1:ACT_W];
	assign value    = s_axis_tdata[IN_W-1:ACT_W+POS_W];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign go            = s_axis_tvalid && s_axis_tready;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign in_range = (CMP_W'(position) < CMP_W'(cnt_q));

	always_comb begin
		ctrl.append_go = 1'b0;
		ctrl.remove_go = 1'b0;
		ctrl.read_go   = 1'b0;
		ctrl.pos       = CMP_W'(position);
		ctrl.cnt       = CMP_W'(cnt_q);
		cnt_next       = cnt_q;
		status         = ST_DONE;
		unique case (action)
			ACT_APPEND: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					ctrl.append_go = go;
					cnt_next       = cnt_q + CNT_W'(1);
				end
			end
			ACT_REMOVE: begin
				if (!in_range) begin
					status = ST_RANGE;
				end else begin
					ctrl.remove_go = go;
					cnt_next       = cnt_q - CNT_W'(1);
				end
			end
			ACT_READ: begin
				if (!in_range) begin
					status = ST_RANGE;
				end else begin
					ctrl.read_go = go;
				end
			end
			default: begin
			end
		endcase
	end

	assign append_val = to_store(value);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t next_val;
		if (i == DEPTH - 1) begin : g_last
			assign next_val = '0;
		end else begin : g_mid
			assign next_val = cell_val[i+1];
		end
		isl_cell u_cell (
			.clk        (clk),
			.idx        (CMP_W'(i)),
			.ctrl       (ctrl),
			.append_val (append_val),
			.next_val   (next_val),
			.val        (cell_val[i]),
			.rd_val     (cell_rd[i])
		);
	end

	always_comb begin
		rd_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				cnt_q <= cnt_next;
			end
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rd_q     <= ctrl.read_go ? from_store(rd_or) : '0;
			ocnt_q   <= OCNT_W'(cnt_next);
			empty_q  <= (cnt_next == '0);
			status_q <= status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TW'({status_q, empty_q, ocnt_q, rd_q});

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("element count above depth");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(go && action == ACT_APPEND && !full) |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("good append did not grow the list");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && status_q != ST_DONE) |-> rd_q == '0)
		else $error("refused operation returned a value");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (empty_q == (ocnt_q == '0)))
		else $error("empty flag disagrees with count");

endmodule
`default_nettype wire
